>>> rtl/core/u8v_pkg.sv
// Shared types and constants for the UTF-8 checker / UTF-16 length counter.
// No dependencies; every other file in rtl/core depends on this package.
package u8v_pkg;

    localparam int COUNT_BITS_DEF = 17;
    localparam int ACCUM_W        = 21;

    // Lead byte ranges
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [7:0] ASCII_HI = 8'h7F;

    // Code point limits
    localparam logic [ACCUM_W-1:0] CP_MIN2    = 21'h000080;
    localparam logic [ACCUM_W-1:0] CP_MIN3    = 21'h000800;
    localparam logic [ACCUM_W-1:0] CP_MIN4    = 21'h010000;
    localparam logic [ACCUM_W-1:0] CP_SURR_LO = 21'h00D800;
    localparam logic [ACCUM_W-1:0] CP_SURR_HI = 21'h00DFFF;
    localparam logic [ACCUM_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [ACCUM_W-1:0] CP_BMP_MAX = 21'h00FFFF;

    localparam logic [1:0] SEQ_W2 = 2'd1;
    localparam logic [1:0] SEQ_W3 = 2'd2;
    localparam logic [1:0] SEQ_W4 = 2'd3;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_SAT     = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_TRUNC   = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_byte_word;

    typedef struct packed {
        logic [1:0] bytes_left;
        logic [1:0] seq_width;
    } t_scan_stat;

endpackage

>>> rtl/core/u8v_if.sv
// Channel interfaces: byte input and per-string result output.
// Depends on u8v_pkg.
interface u8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface u8v_result_if #(
    parameter int COUNT_BITS = u8v_pkg::COUNT_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] unit_count;
    logic [1:0]            status;

    modport source (output valid, output unit_count, output status, input ready);
    modport sink   (input valid, input unit_count, input status, output ready);
endinterface

>>> rtl/core/u8v_in_stage.sv
// Input register: holds one byte word between the channel and the scan stage.
// Depends on u8v_pkg and u8v_byte_if.
module u8v_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    u8v_byte_if.sink            i_byte,
    input  logic                i_take,
    output logic                o_valid,
    output u8v_pkg::t_byte_word o_word
);
    import u8v_pkg::*;

    logic       r_valid;
    t_byte_word r_word;

    assign i_byte.ready = !r_valid || i_take;
    assign o_valid      = r_valid;
    assign o_word       = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_word <= '{byte_value: i_byte.byte_value, last_byte: i_byte.last_byte};
        end
    end

endmodule

>>> rtl/core/u8v_scan.sv
// Scan stage: per-string decode state, validation and UTF-16 unit count.
// Depends on u8v_pkg.
module u8v_scan #(
    parameter int COUNT_BITS = u8v_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  u8v_pkg::t_byte_word   i_word,
    input  logic                  i_out_free,
    output logic                  o_take,
    output logic                  o_res_valid,
    output logic [COUNT_BITS-1:0] o_unit_count,
    output u8v_pkg::t_status      o_status,
    output u8v_pkg::t_scan_stat   o_stat
);
    import u8v_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [1:0]            r_bytes_left, n_bytes_left;
    logic [1:0]            r_seq_width,  n_seq_width;
    logic [ACCUM_W-1:0]    r_accum,      n_accum;
    logic                  r_bad_cont,   n_bad_cont;
    t_err                  r_err,        n_err;
    logic [COUNT_BITS-1:0] r_total,      n_total;

    logic [1:0]            add_n;
    logic [COUNT_BITS:0]   sum;
    logic                  overlong;
    logic [7:0]            b;

    assign b           = i_word.byte_value;
    assign o_take      = i_valid && (!i_word.last_byte || i_out_free);
    assign o_res_valid = o_take && i_word.last_byte;
    assign o_stat      = '{bytes_left: r_bytes_left, seq_width: r_seq_width};

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_seq_width  = r_seq_width;
        n_accum      = r_accum;
        n_bad_cont   = r_bad_cont;
        n_err        = r_err;
        n_total      = r_total;
        add_n        = 2'd0;
        overlong     = 1'b0;

        if (r_err != ERR_INVALID) begin
            if (r_bytes_left == 2'd0) begin
                if (b <= ASCII_HI) begin
                    add_n = 2'd1;
                end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                    n_seq_width  = SEQ_W2;
                    n_accum      = {16'd0, b[4:0]};
                    n_bytes_left = SEQ_W2;
                    n_bad_cont   = 1'b0;
                end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                    n_seq_width  = SEQ_W3;
                    n_accum      = {17'd0, b[3:0]};
                    n_bytes_left = SEQ_W3;
                    n_bad_cont   = 1'b0;
                end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                    n_seq_width  = SEQ_W4;
                    n_accum      = {18'd0, b[2:0]};
                    n_bytes_left = SEQ_W4;
                    n_bad_cont   = 1'b0;
                end else begin
                    n_err = ERR_INVALID;
                end
            end else begin
                // bad continuation bytes are still consumed
                if (b[7:6] != 2'b10) begin
                    n_bad_cont = 1'b1;
                end
                n_accum      = {r_accum[ACCUM_W-7:0], b[5:0]};
                n_bytes_left = r_bytes_left - 2'd1;
                if (n_bytes_left == 2'd0) begin
                    overlong = (r_seq_width == SEQ_W2 && n_accum < CP_MIN2) ||
                               (r_seq_width == SEQ_W3 && n_accum < CP_MIN3) ||
                               (r_seq_width == SEQ_W4 && n_accum < CP_MIN4);
                    if (n_bad_cont || overlong ||
                        (n_accum >= CP_SURR_LO && n_accum <= CP_SURR_HI) ||
                        n_accum > CP_MAX) begin
                        n_err = ERR_INVALID;
                    end else if (n_accum > CP_BMP_MAX) begin
                        add_n = 2'd2;
                    end else begin
                        add_n = 2'd1;
                    end
                end
            end
        end

        sum = {1'b0, r_total} + {{(COUNT_BITS-1){1'b0}}, add_n};
        if (add_n != 2'd0) begin
            if (sum[COUNT_BITS]) begin
                n_total = COUNT_MAX;
                n_err   = ERR_SAT;
            end else begin
                n_total = sum[COUNT_BITS-1:0];
            end
        end
    end

    // result word for the string, valid with o_res_valid
    always_comb begin
        if (n_err == ERR_INVALID) begin
            o_status     = ST_INVALID;
            o_unit_count = '0;
        end else if (n_bytes_left != 2'd0) begin
            o_status     = ST_TRUNC;
            o_unit_count = '0;
        end else if (n_err == ERR_SAT) begin
            o_status     = ST_SAT;
            o_unit_count = COUNT_MAX;
        end else begin
            o_status     = ST_OK;
            o_unit_count = n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_valid) begin
            r_bytes_left <= 2'd0;
            r_seq_width  <= 2'd0;
            r_accum      <= '0;
            r_bad_cont   <= 1'b0;
            r_err        <= ERR_NONE;
            r_total      <= '0;
        end else if (o_take) begin
            r_bytes_left <= n_bytes_left;
            r_seq_width  <= n_seq_width;
            r_accum      <= n_accum;
            r_bad_cont   <= n_bad_cont;
            r_err        <= n_err;
            r_total      <= n_total;
        end
    end

endmodule

>>> rtl/core/u8v_out_stage.sv
// Result register: holds one result word until the receiver takes it.
// Depends on u8v_pkg and u8v_result_if.
module u8v_out_stage #(
    parameter int COUNT_BITS = u8v_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [COUNT_BITS-1:0] i_unit_count,
    input  u8v_pkg::t_status      i_status,
    output logic                  o_free,
    u8v_result_if.source          o_result
);
    import u8v_pkg::*;

    logic                  r_valid;
    logic [COUNT_BITS-1:0] r_count;
    t_status               r_status;

    assign o_free              = !r_valid || o_result.ready;
    assign o_result.valid      = r_valid;
    assign o_result.unit_count = r_count;
    assign o_result.status     = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_count  <= i_unit_count;
            r_status <= i_status;
        end
    end

endmodule

>>> rtl/core/utf8_validate_utf16_count.sv
// Top level of the UTF-8 checker / UTF-16 length counter.
// Depends on u8v_pkg, u8v_if, u8v_in_stage, u8v_scan, u8v_out_stage.
//
// Usage:
//   i_byte carries one byte of an encoded string per word, with last_byte set
//   on the final byte. o_result gives exactly one word per string: the
//   UTF-16 unit count and a status (ok, invalid, truncated, saturated).
//   The count is zero for invalid or truncated strings and all ones when
//   it saturated.
// Timing:
//   Throughput is one byte per cycle while no final byte waits on a full
//   result register. A byte passes an input register, then the scan stage
//   updates the per-string decode state; that state loop sets the rate.
//   The scan stage loads the result register as it takes a final byte.
// Reset:
//   i_rst_n (synchronous, active low) empties both registers and clears the
//   decode state; the first byte after reset starts a new string.
// Back-pressure:
//   While the result register holds an untaken word, bytes that are not the
//   end of a string keep flowing; the next final byte waits in the input
//   register and i_byte.ready drops until the result is taken.
module utf8_validate_utf16_count #(
    parameter int COUNT_BITS = u8v_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8v_byte_if.sink      i_byte,
    u8v_result_if.source  o_result
);
    import u8v_pkg::*;

    logic                  in_valid;
    t_byte_word            in_word;
    logic                  take;
    logic                  out_free;
    logic                  res_valid;
    logic [COUNT_BITS-1:0] res_count;
    t_status               res_status;
    t_scan_stat            scan_stat;

    u8v_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_take  (take),
        .o_valid (in_valid),
        .o_word  (in_word)
    );

    u8v_scan #(.COUNT_BITS(COUNT_BITS)) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_valid),
        .i_word       (in_word),
        .i_out_free   (out_free),
        .o_take       (take),
        .o_res_valid  (res_valid),
        .o_unit_count (res_count),
        .o_status     (res_status),
        .o_stat       (scan_stat)
    );

    u8v_out_stage #(.COUNT_BITS(COUNT_BITS)) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (res_valid),
        .i_unit_count (res_count),
        .i_status     (res_status),
        .o_free       (out_free),
        .o_result     (o_result)
    );

    // Failed strings report a zero count
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (o_result.status == ST_INVALID || o_result.status == ST_TRUNC)
        |-> o_result.unit_count == '0)
        else $error("failed string with nonzero count");

    // Saturated strings report the full-scale count
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.status == ST_SAT |-> &o_result.unit_count)
        else $error("saturated status without full-scale count");

    // Remaining continuation bytes never exceed the sequence length
    a_seq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_stat.bytes_left <= scan_stat.seq_width)
        else $error("continuation count exceeds sequence length");

    // A final byte in the scan stage only stalls on a full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && !take |-> in_word.last_byte && !out_free)
        else $error("scan stage stalled without cause");

endmodule
